// ===== sv/mmts_pkg.sv =====
// shared types and constants of the march memory test sequencer
// no dependencies; imported by every module of the block

package mmts_pkg;

  localparam int unsigned AddrBits = 32;
  localparam int unsigned WordBits = 64;
  localparam int unsigned CfgAddrBits = 5;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned CntBits = 32;

  typedef enum logic [1:0] {
    REG_START_ADDRESS = 2'd0,
    REG_END_ADDRESS   = 2'd1,
    REG_COMPARE_MASK  = 2'd2,
    REG_ALGORITHM     = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_W0    = 3'd0,
    PH_UP    = 3'd1,
    PH_DOWN  = 3'd2,
    PH_FINAL = 3'd3,
    PH_DRAIN = 3'd4
  } phase_e;

  localparam logic ALG_MARCH_X = 1'b0;
  localparam logic ALG_MARCH_Y = 1'b1;

  typedef struct packed {
    logic [AddrBits-1:0] start_address;
    logic [AddrBits-1:0] end_address;
    logic [WordBits-1:0] compare_mask;
    logic                algorithm;
  } cfg_t;

  typedef struct packed {
    logic                start_req;
    logic [WordBits-1:0] read_data;
  } item_t;

  typedef struct packed {
    logic [AddrBits-1:0] mem_address;
    logic                op_valid;
    logic                op_is_write;
    logic                write_ones;
    logic                check_valid;
    logic                check_failed;
    logic [AddrBits-1:0] check_address;
    logic                check_expected_ones;
    logic [WordBits-1:0] check_actual;
    logic [CntBits-1:0]  failure_count;
    logic                run_done;
  } result_t;

endpackage

// ===== sv/march_memory_test_sequencer_core.sv =====
// top level of the march x / march y memory self-test sequencer
// depends on mmts_pkg, mmts_regs, mmts_front, mmts_engine
//
// usage:
//   input side is a queue: a request (start_req_i, read_data_i) is taken at a
//   clock edge with push high and full low. a start request begins a run;
//   every later request carries the data read by the previous result's op.
//   result side is a queue: the oldest result is on the *_o payload ports
//   while empty is low and is taken at an edge with pop high.
//   each request yields exactly one result: the memory op to issue now, the
//   compare of the returned read data, the failure count and run_done.
//   a request is held in the request queue, then its result is registered into the result queue.
//   throughput: one request per cycle while pop stays high, set by the
//   combinational sequencer step; two-entry queues on both sides keep that rate.
//   when pop stays low the result queue fills, the sequencer holds, then the
//   request queue fills and full rises; nothing is dropped.
//   reset clears both queues and the run state; registers return to their
//   defaults (compare mask all ones, march x). the user must write configuration
//   over the apb port only while no run is in flight; the block does not enforce it.

module march_memory_test_sequencer_core
  import mmts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [CfgDataBits-1:0] pwdata,
  output logic [CfgDataBits-1:0] prdata,
  output logic                   pready,
  input  logic                   push,
  output logic                   full,
  input  logic                   start_req_i,
  input  logic [WordBits-1:0]    read_data_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [AddrBits-1:0]    mem_address_o,
  output logic                   op_valid_o,
  output logic                   op_is_write_o,
  output logic                   write_ones_o,
  output logic                   check_valid_o,
  output logic                   check_failed_o,
  output logic [AddrBits-1:0]    check_address_o,
  output logic                   check_expected_ones_o,
  output logic [WordBits-1:0]    check_actual_o,
  output logic [CntBits-1:0]     failure_count_o,
  output logic                   run_done_o
);

  cfg_t    cfg;
  item_t   in_item, q_item;
  logic    q_valid, q_take;
  result_t res;

  assign in_item.start_req = start_req_i;
  assign in_item.read_data = read_data_i;

  mmts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mmts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_take_i  (q_take)
  );

  mmts_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .empty        (empty),
    .pop          (pop),
    .result_o     (res)
  );

  assign mem_address_o         = res.mem_address;
  assign op_valid_o            = res.op_valid;
  assign op_is_write_o         = res.op_is_write;
  assign write_ones_o          = res.write_ones;
  assign check_valid_o         = res.check_valid;
  assign check_failed_o        = res.check_failed;
  assign check_address_o       = res.check_address;
  assign check_expected_ones_o = res.check_expected_ones;
  assign check_actual_o        = res.check_actual;
  assign failure_count_o       = res.failure_count;
  assign run_done_o            = res.run_done;

endmodule

// ===== sv/mmts_regs.sv =====
// apb configuration registers: start/end address, compare mask, algorithm
// depends on mmts_pkg

module mmts_regs
  import mmts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [CfgDataBits-1:0] pwdata,
  output logic [CfgDataBits-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_START_ADDRESS: cfg_d.start_address = pwdata[AddrBits-1:0];
        REG_END_ADDRESS:   cfg_d.end_address   = pwdata[AddrBits-1:0];
        REG_COMPARE_MASK:  cfg_d.compare_mask  = pwdata[WordBits-1:0];
        REG_ALGORITHM:     cfg_d.algorithm     = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_START_ADDRESS: prdata[AddrBits-1:0] = cfg_q.start_address;
      REG_END_ADDRESS:   prdata[AddrBits-1:0] = cfg_q.end_address;
      REG_COMPARE_MASK:  prdata[WordBits-1:0] = cfg_q.compare_mask;
      REG_ALGORITHM:     prdata[0]            = cfg_q.algorithm;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_address <= '0;
      cfg_q.end_address   <= '0;
      cfg_q.compare_mask  <= '1;
      cfg_q.algorithm     <= ALG_MARCH_X;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/mmts_front.sv =====
// front end: two-entry request queue that accepts and holds input items
// depends on mmts_pkg

module mmts_front
  import mmts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  item_t item_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_take_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== sv/mmts_engine.sv =====
// back end: march sequencer state, read compare, failure count, result queue
// depends on mmts_pkg

module mmts_engine
  import mmts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_take_o,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  // sequencer state
  logic                busy_q, busy_d;
  phase_e              phase_q, phase_d;
  logic [1:0]          step_q, step_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic                pend_q, pend_d;
  logic                pend_ones_q, pend_ones_d;
  logic [AddrBits-1:0] pend_addr_q, pend_addr_d;
  logic [CntBits-1:0]  fail_q, fail_d;

  // result queue
  result_t    oq_q [2];
  logic       owr_q, owr_d, ord_q, ord_d;
  logic [1:0] ocnt_q, ocnt_d;
  logic       do_pop;

  // issue path
  logic                do_issue;
  phase_e              iss_phase;
  logic [1:0]          iss_step;
  logic [AddrBits-1:0] iss_addr;
  logic                is_write, ones, last;
  logic [1:0]          nsteps;
  logic [AddrBits:0]   addr_inc;
  logic [WordBits-1:0] actual, expected;
  logic                failed;
  result_t             res;

  assign item_take_o = item_valid_i && (ocnt_q != 2'd2);
  assign empty       = (ocnt_q == 2'd0);
  assign result_o    = oq_q[ord_q];
  assign do_pop      = pop && !empty;

  assign actual   = item_i.read_data & cfg_i.compare_mask;
  assign expected = pend_ones_q ? cfg_i.compare_mask : '0;
  assign failed   = (actual != expected);
  assign addr_inc = {1'b0, iss_addr} + {{AddrBits{1'b0}}, 1'b1};

  // operation decode for the element being issued
  always_comb begin
    nsteps = 2'd1;
    if (iss_phase == PH_UP || iss_phase == PH_DOWN) begin
      nsteps = (cfg_i.algorithm == ALG_MARCH_Y) ? 2'd3 : 2'd2;
    end
    case (iss_phase)
      PH_W0: begin
        is_write = 1'b1;
        ones     = 1'b0;
      end
      PH_UP: begin
        is_write = (iss_step == 2'd1);
        ones     = (iss_step != 2'd0);
      end
      PH_DOWN: begin
        is_write = (iss_step == 2'd1);
        ones     = (iss_step == 2'd0);
      end
      default: begin
        is_write = 1'b0;
        ones     = 1'b0;
      end
    endcase
    last = ({1'b0, iss_step} + 3'd1) >= {1'b0, nsteps};
  end

  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    step_d      = step_q;
    addr_d      = addr_q;
    pend_d      = pend_q;
    pend_ones_d = pend_ones_q;
    pend_addr_d = pend_addr_q;
    fail_d      = fail_q;
    res         = '0;
    do_issue    = 1'b0;
    iss_phase   = phase_q;
    iss_step    = step_q;
    iss_addr    = addr_q;

    if (!busy_q) begin
      if (item_i.start_req) begin
        fail_d  = '0;
        pend_d  = 1'b0;
        phase_d = PH_W0;
        step_d  = 2'd0;
        addr_d  = cfg_i.start_address;
        if (cfg_i.end_address <= cfg_i.start_address) begin
          res.run_done = 1'b1;
        end else begin
          busy_d    = 1'b1;
          do_issue  = 1'b1;
          iss_phase = PH_W0;
          iss_step  = 2'd0;
          iss_addr  = cfg_i.start_address;
        end
      end
    end else begin
      if (pend_q) begin
        if (failed && fail_q != '1) begin
          fail_d = fail_q + CntBits'(1);
        end
        res.check_valid         = 1'b1;
        res.check_failed        = failed;
        res.check_address       = pend_addr_q;
        res.check_expected_ones = pend_ones_q;
        res.check_actual        = actual;
        pend_d                  = 1'b0;
      end
      if (phase_q == PH_DRAIN) begin
        busy_d       = 1'b0;
        phase_d      = PH_W0;
        step_d       = 2'd0;
        res.run_done = 1'b1;
      end else begin
        do_issue = 1'b1;
      end
    end

    if (do_issue) begin
      res.mem_address = iss_addr;
      res.op_valid    = 1'b1;
      res.op_is_write = is_write;
      res.write_ones  = is_write && ones;
      if (!is_write) begin
        pend_d      = 1'b1;
        pend_ones_d = ones;
        pend_addr_d = iss_addr;
      end
      if (!last) begin
        step_d = iss_step + 2'd1;
      end else begin
        step_d = 2'd0;
        if (iss_phase == PH_DOWN) begin
          if (iss_addr <= cfg_i.start_address) begin
            phase_d = PH_FINAL;
            addr_d  = cfg_i.start_address;
          end else begin
            addr_d = iss_addr - AddrBits'(1);
          end
        end else if (addr_inc >= {1'b0, cfg_i.end_address}) begin
          case (iss_phase)
            PH_W0: begin
              phase_d = PH_UP;
              addr_d  = cfg_i.start_address;
            end
            PH_UP: begin
              phase_d = PH_DOWN;
              addr_d  = cfg_i.end_address - AddrBits'(1);
            end
            default: begin
              phase_d = PH_DRAIN;
            end
          endcase
        end else begin
          addr_d = addr_inc[AddrBits-1:0];
        end
      end
    end

    res.failure_count = fail_d;
  end

  always_comb begin
    owr_d  = owr_q ^ item_take_o;
    ord_d  = ord_q ^ do_pop;
    ocnt_d = ocnt_q + {1'b0, item_take_o} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      oq_q[owr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_W0;
      step_q      <= 2'd0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      pend_ones_q <= 1'b0;
      pend_addr_q <= '0;
      fail_q      <= '0;
      owr_q       <= 1'b0;
      ord_q       <= 1'b0;
      ocnt_q      <= 2'd0;
    end else begin
      if (item_take_o) begin
        busy_q      <= busy_d;
        phase_q     <= phase_d;
        step_q      <= step_d;
        addr_q      <= addr_d;
        pend_q      <= pend_d;
        pend_ones_q <= pend_ones_d;
        pend_addr_q <= pend_addr_d;
        fail_q      <= fail_d;
      end
      owr_q  <= owr_d;
      ord_q  <= ord_d;
      ocnt_q <= ocnt_d;
    end
  end

endmodule
